/* sv/ffa_pkg.sv */
// shared types, codes and defaults for the first-fit allocator
package ffa_pkg;

    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEADER_BYTES = 24;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;

    typedef struct packed {
        logic [23:0] base;
        logic [23:0] size;
        logic        free;
    } entry_t;

    typedef struct packed {
        logic       load;
        logic       scan;
        logic       append;
        logic       neigh;
        logic       shift;
        logic       finish;
        logic       grant;
        logic [2:0] fin_status;
    } cmd_t;

    typedef struct packed {
        logic alloc_op;
        logic zero_req;
        logic null_free;
        logic hit;
        logic miss;
        logic exhausted;
        logic full;
        logic no_merge;
        logic shift_done;
    } stat_t;

endpackage

/* sv/ffa_ctrl.sv */
// controller state machine for the first-fit allocator
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_APPEND = 6'b001000,
        S_NEIGH  = 6'b010000,
        S_SHIFT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.fin_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.alloc_op && stat.zero_req)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_ZERO;
                    state_next     = S_IDLE;
                end
                else if (!stat.alloc_op && stat.null_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    if (stat.alloc_op)
                    begin
                        cmd.finish = 1'b1;
                        cmd.grant  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_NEIGH;
                    end
                end
                else if (stat.miss)
                begin
                    if (stat.alloc_op)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_UNKNOWN;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                cmd.finish = 1'b1;
                state_next = S_IDLE;
                priority if (stat.exhausted)
                begin
                    cmd.fin_status = ST_EXHAUSTED;
                end
                else if (stat.full)
                begin
                    cmd.fin_status = ST_FULL;
                end
                else
                begin
                    cmd.grant = 1'b1;
                end
            end
            S_NEIGH:
            begin
                cmd.neigh = 1'b1;
                if (stat.no_merge)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/ffa_dp.sv */
// datapath of the first-fit allocator: block table memory, scan, merge and shift
module ffa_dp
    import ffa_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        opcode,
    input  logic [19:0] request_size,
    input  logic [23:0] data_address,
    input  logic        heap_limit_we,
    input  logic [23:0] heap_limit,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [23:0] granted_address,
    output logic [23:0] granted_size
);

    localparam int ADDR_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam logic [23:0]      HDR      = 24'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BLOCKS);

    entry_t mem [MAX_BLOCKS];

    logic [23:0]      limit_reg;
    logic [23:0]      top_reg;
    logic [CNT_W-1:0] count_reg;
    logic             op_reg;
    logic [23:0]      need_reg;
    logic [23:0]      addr_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic             rv_reg;
    entry_t           rd_data_reg;
    entry_t           cur_reg;
    logic [CNT_W-1:0] cur_idx_reg;
    entry_t           prev_reg;
    logic [CNT_W-1:0] dst_reg;
    logic [1:0]       r_reg;
    logic             done_reg;
    logic [2:0]       status_reg;
    logic [23:0]      gaddr_reg;
    logic [23:0]      gsize_reg;

    logic [20:0]      need_c;
    logic             pending;
    logic             issue;
    logic             match;
    logic             hit;
    logic [25:0]      new_top;
    logic             exhausted;
    logic             full;
    logic             next_free;
    logic             prev_free;
    logic [1:0]       r_c;
    logic [CNT_W-1:0] p_c;
    entry_t           merged;
    logic             wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [23:0]      grant_addr;
    logic [23:0]      grant_size;

    assign need_c    = (21'(request_size) + 21'd3) & ~21'd3;
    assign pending   = (idx_reg < count_reg);
    assign issue     = (cmd.scan || cmd.shift) && pending;
    assign match     = (op_reg == OP_ALLOC)
                       ? (rd_data_reg.free && (rd_data_reg.size >= need_reg))
                       : ((rd_data_reg.base + HDR) == addr_reg);
    assign hit       = rv_reg && match;
    assign new_top   = 26'(top_reg) + 26'(HDR) + 26'(need_reg);
    assign exhausted = (new_top > 26'(limit_reg));
    assign full      = (count_reg >= CNT_FULL);

    assign next_free = rv_reg && rd_data_reg.free;
    assign prev_free = (cur_idx_reg != '0) && prev_reg.free;
    assign r_c       = {1'b0, next_free} + {1'b0, prev_free};
    assign p_c       = prev_free ? (cur_idx_reg - CNT_W'(1)) : cur_idx_reg;

    always_comb
    begin
        merged.free = 1'b1;
        merged.base = prev_free ? prev_reg.base : cur_reg.base;
        merged.size = cur_reg.size
                      + (prev_free ? (prev_reg.size + HDR) : 24'd0)
                      + (next_free ? (rd_data_reg.size + HDR) : 24'd0);
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg[ADDR_W-1:0];
        wr_data = rd_data_reg;
        priority if (cmd.scan && hit && (op_reg == OP_ALLOC))
        begin
            wr_en        = 1'b1;
            wr_data.free = 1'b0;
        end
        else if (cmd.append && !exhausted && !full)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[ADDR_W-1:0];
            wr_data = '{base: top_reg, size: need_reg, free: 1'b0};
        end
        else if (cmd.neigh)
        begin
            wr_en   = 1'b1;
            wr_addr = p_c[ADDR_W-1:0];
            wr_data = merged;
        end
        else if (cmd.shift && rv_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = dst_reg[ADDR_W-1:0];
        end
    end

    assign grant_addr = cmd.append ? (top_reg + HDR) : (rd_data_reg.base + HDR);
    assign grant_size = cmd.append ? need_reg : rd_data_reg.size;

    always_comb
    begin
        stat            = '0;
        stat.alloc_op   = (op_reg == OP_ALLOC);
        stat.zero_req   = (need_reg == '0);
        stat.null_free  = (addr_reg == '0);
        stat.hit        = hit;
        stat.miss       = !rv_reg && !pending;
        stat.exhausted  = exhausted;
        stat.full       = full;
        stat.no_merge   = (r_c == 2'd0);
        stat.shift_done = !rv_reg && !pending;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            need_reg <= 24'(need_c);
            addr_reg <= data_address;
        end
        if (issue)
        begin
            rd_idx_reg <= idx_reg;
        end
        if (cmd.scan && rv_reg && !hit)
        begin
            prev_reg <= rd_data_reg;
        end
        if (cmd.scan && hit)
        begin
            cur_reg     <= rd_data_reg;
            cur_idx_reg <= rd_idx_reg;
        end
        if (cmd.neigh)
        begin
            dst_reg <= p_c + CNT_W'(1);
            r_reg   <= r_c;
        end
        else if (cmd.shift && rv_reg)
        begin
            dst_reg <= dst_reg + CNT_W'(1);
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.fin_status;
            gaddr_reg  <= cmd.grant ? grant_addr : 24'd0;
            gsize_reg  <= cmd.grant ? grant_size : 24'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 24'hFFFFFF;
            top_reg   <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            rv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (heap_limit_we)
            begin
                limit_reg <= heap_limit;
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
                rv_reg  <= 1'b0;
            end
            else if (cmd.neigh)
            begin
                idx_reg <= p_c + CNT_W'(1) + CNT_W'(r_c);
                rv_reg  <= 1'b0;
            end
            else if (cmd.scan || cmd.shift)
            begin
                rv_reg <= issue;
                if (issue)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
            if (cmd.append && !exhausted && !full)
            begin
                count_reg <= count_reg + CNT_W'(1);
                top_reg   <= new_top[23:0];
            end
            if (cmd.shift && !rv_reg && !pending)
            begin
                count_reg <= count_reg - CNT_W'(r_reg);
            end
        end
    end

    assign result_valid    = done_reg;
    assign status          = status_reg;
    assign granted_address = gaddr_reg;
    assign granted_size    = gsize_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("block count above table size");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != ST_OK)) |-> (gaddr_reg == '0 && gsize_reg == '0))
        else $error("failed transaction carries a grant");

    a_shift_dst: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift && rv_reg) |-> (dst_reg < idx_reg))
        else $error("shift destination not below source");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && cmd.grant) |=> (status_reg == ST_OK && gsize_reg != '0))
        else $error("grant without ok status");

endmodule

/* sv/first_fit_allocator_coalescing.sv */
// top level of the first-fit heap block allocator with coalescing
// One transaction at a time: start is taken while busy is low, and the result appears on
// status, granted_address and granted_size for exactly one cycle with result_valid high,
// in the same cycle that busy falls; it cannot be held off. The block table sits in a
// memory with one read and one write port, so a transaction walks it one entry per cycle:
// an allocate stops at the first free entry large enough, an allocate that misses appends
// a new entry after the last, and a free that merges moves the later entries down.
// No clearing pass is needed after reset. heap_limit is to be written only while
// the block is idle; the block itself does not enforce it.
module first_fit_allocator_coalescing
    import ffa_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [19:0] request_size,
    input  logic [23:0] data_address,
    input  logic        heap_limit_we,
    input  logic [23:0] heap_limit,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [23:0] granted_address,
    output logic [23:0] granted_size
);

    cmd_t  cmd;
    stat_t stat;

    ffa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ffa_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .opcode          (opcode),
        .request_size    (request_size),
        .data_address    (data_address),
        .heap_limit_we   (heap_limit_we),
        .heap_limit      (heap_limit),
        .result_valid    (result_valid),
        .status          (status),
        .granted_address (granted_address),
        .granted_size    (granted_size)
    );

endmodule
